@@ rtl/core/brb_pkg.sv @@
package brb_pkg;

  // Field widths fixed by the interface.
  localparam int KIND_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CNT_W  = 9;

  // Operation codes carried on kind and op_kind.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Burst counter saturation value and capacity after reset.
  localparam logic [CNT_W-1:0] CNT_MAX   = 9'd511;
  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] wbyte;
    logic              wlast;
    logic [LEN_W-1:0]  rlen;
  } cmd_t;

  // One result item as it sits in the result queue.
  typedef struct packed {
    logic [KIND_W-1:0] op_kind;
    logic [BYTE_W-1:0] data_byte;
    logic              byte_valid;
    logic [CNT_W-1:0]  transfer_count;
    logic              last_of_run;
    logic [CNT_W-1:0]  fill_level;
  } result_t;

endpackage

@@ rtl/core/brb_front.sv @@
module brb_front #(
  parameter int MAX_READ = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic [brb_pkg::KIND_W-1:0] in_kind,
  input  logic [brb_pkg::BYTE_W-1:0] in_write_byte,
  input  logic                    in_write_last,
  input  logic [brb_pkg::LEN_W-1:0]  in_read_length,
  output logic                    cmd_valid,
  output brb_pkg::cmd_t           cmd,
  input  logic                    cmd_pop
);
  import brb_pkg::*;

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_READ);

  cmd_t       ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cmd_in;
  logic       known;
  logic       enq;
  logic       deq;

  // Classify the item: unknown kinds are taken and dropped, long reads saturate.
  always_comb begin
    known = (in_kind inside {KIND_WRITE, KIND_READ, KIND_CLEAR});
    cmd_in.kind  = in_kind;
    cmd_in.wbyte = in_write_byte;
    cmd_in.wlast = in_write_last;
    cmd_in.rlen  = (in_read_length > MaxLen) ? MaxLen : in_read_length;
  end

  assign full      = (cnt_r == 2'd2);
  assign enq       = push && !full && known;
  assign deq       = cmd_pop && (cnt_r != 2'd0);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rptr_r];

  // Two-entry command queue pointers and occupancy.
  always_comb begin
    wptr_nxt = enq ? ~wptr_r : wptr_r;
    rptr_nxt = deq ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Command storage needs no reset.
  always_ff @(posedge clk) begin
    if (enq) begin
      ent_r[wptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/core/brb_back.sv @@
module brb_back #(
  parameter int BUF_DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [brb_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                      cmd_valid,
  input  brb_pkg::cmd_t             cmd,
  output logic                      cmd_pop,
  output logic                      res_push,
  output brb_pkg::result_t          res,
  input  logic                      res_full
);
  import brb_pkg::*;

  localparam int IW   = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CMPW = (IW + 1 > CNT_W) ? IW + 1 : CNT_W;
  localparam logic [CMPW-1:0] DepthC = CMPW'(BUF_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_RD_ADDR = 3'b010,
    ST_RD_DATA = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      widx_r, widx_nxt;
  logic [IW-1:0]      ridx_r, ridx_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   burst_r, burst_nxt;
  logic [CNT_W-1:0]   cap_r;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   n_r, n_nxt;
  logic [BYTE_W-1:0]  rd_data_r;
  logic [BYTE_W-1:0]  mem [BUF_DEPTH];

  logic [CMPW-1:0]    cap_eff;
  logic               room;
  logic [CNT_W-1:0]   burst_upd;
  logic [LEN_W-1:0]   n_calc;
  logic               wr_en;
  logic               rd_en;
  logic               last_byte;

  // Step an index, wrapping to zero at the capacity.
  function automatic logic [IW-1:0] adv(input logic [IW-1:0] idx,
                                        input logic [CMPW-1:0] cap);
    logic [CMPW-1:0] n;
    n = CMPW'(idx) + CMPW'(1);
    adv = (n >= cap) ? '0 : n[IW-1:0];
  endfunction

  // Effective capacity: zero acts as one, anything past the store as its depth.
  always_comb begin
    cap_eff = CMPW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_eff > DepthC) begin
      cap_eff = DepthC;
    end
  end

  assign room      = (CMPW'(fill_r) < cap_eff);
  assign burst_upd = (room && (burst_r < CNT_MAX)) ? burst_r + 9'd1 : burst_r;
  assign n_calc    = (fill_r < CNT_W'(cmd.rlen)) ? fill_r[LEN_W-1:0] : cmd.rlen;
  assign last_byte = (rem_r == LEN_W'(1));

  // Sequencer: writes and clears in idle; read bytes via RD_ADDR, RD_DATA.
  always_comb begin
    state_nxt = state_r;
    widx_nxt  = widx_r;
    ridx_nxt  = ridx_r;
    fill_nxt  = fill_r;
    burst_nxt = burst_r;
    rem_nxt   = rem_r;
    n_nxt     = n_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            KIND_WRITE: begin
              if (room) begin
                wr_en    = 1'b1;
                widx_nxt = adv(widx_r, cap_eff);
                fill_nxt = fill_r + 9'd1;
              end
              burst_nxt = burst_upd;
              if (cmd.wlast) begin
                res_push           = 1'b1;
                res.op_kind        = KIND_WRITE;
                res.transfer_count = burst_upd;
                res.last_of_run    = 1'b1;
                res.fill_level     = fill_nxt;
                burst_nxt          = '0;
              end
            end
            KIND_READ: begin
              if (n_calc == '0) begin
                res_push        = 1'b1;
                res.op_kind     = KIND_READ;
                res.last_of_run = 1'b1;
                res.fill_level  = fill_r;
              end else begin
                rem_nxt   = n_calc;
                n_nxt     = n_calc;
                state_nxt = ST_RD_ADDR;
              end
            end
            KIND_CLEAR: begin
              widx_nxt        = '0;
              ridx_nxt        = '0;
              fill_nxt        = '0;
              res_push        = 1'b1;
              res.op_kind     = KIND_CLEAR;
              res.last_of_run = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_ADDR: begin
        rd_en     = 1'b1;
        ridx_nxt  = adv(ridx_r, cap_eff);
        fill_nxt  = fill_r - 9'd1;
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (!res_full) begin
          res_push           = 1'b1;
          res.op_kind        = KIND_READ;
          res.data_byte      = rd_data_r;
          res.byte_valid     = 1'b1;
          res.transfer_count = last_byte ? CNT_W'(n_r) : '0;
          res.last_of_run    = last_byte;
          res.fill_level     = fill_r;
          rem_nxt            = rem_r - LEN_W'(1);
          state_nxt          = last_byte ? ST_IDLE : ST_RD_ADDR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and the capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      widx_r  <= '0;
      ridx_r  <= '0;
      fill_r  <= '0;
      burst_r <= '0;
      rem_r   <= '0;
      n_r     <= '0;
      cap_r   <= CAP_RESET;
    end else begin
      state_r <= state_nxt;
      widx_r  <= widx_nxt;
      ridx_r  <= ridx_nxt;
      fill_r  <= fill_nxt;
      burst_r <= burst_nxt;
      rem_r   <= rem_nxt;
      n_r     <= n_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[widx_r] <= cmd.wbyte;
    end
    if (rd_en) begin
      rd_data_r <= mem[ridx_r];
    end
  end

endmodule

@@ rtl/core/brb_out_q.sv @@
module brb_out_q (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        res_push,
  input  brb_pkg::result_t            res,
  output logic                        res_full,
  output logic                        empty,
  input  logic                        pop,
  output logic [brb_pkg::KIND_W-1:0]  out_op_kind,
  output logic [brb_pkg::BYTE_W-1:0]  out_data_byte,
  output logic                        out_byte_valid,
  output logic [brb_pkg::CNT_W-1:0]   out_transfer_count,
  output logic                        out_last_of_run,
  output logic [brb_pkg::CNT_W-1:0]   out_fill_level
);
  import brb_pkg::*;

  result_t    ent_r [2];
  result_t    head;
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       enq;
  logic       deq;

  assign res_full = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign enq      = res_push && !res_full;
  assign deq      = pop && !empty;
  assign head     = ent_r[rptr_r];

  // The oldest result drives the result ports.
  assign out_op_kind        = head.op_kind;
  assign out_data_byte      = head.data_byte;
  assign out_byte_valid     = head.byte_valid;
  assign out_transfer_count = head.transfer_count;
  assign out_last_of_run    = head.last_of_run;
  assign out_fill_level     = head.fill_level;

  // Two-entry result queue pointers and occupancy.
  always_comb begin
    wptr_nxt = enq ? ~wptr_r : wptr_r;
    rptr_nxt = deq ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!enq && deq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result storage needs no reset.
  always_ff @(posedge clk) begin
    if (enq) begin
      ent_r[wptr_r] <= res;
    end
  end

endmodule

@@ rtl/core/byte_ring_buffer.sv @@
// A write-last, clear or empty-read result reaches the result ports through the command
// and result queues; the first byte of a read also passes the address state and the
// registered store read. Write and clear items run at one per cycle while the result
// queue has room and no read is in progress; a read emits one byte at a time through the
// address and data states. Reset (synchronous, rst_n low) empties both queues, zeroes indices,
// fill and burst count, sets capacity to 256 and leaves the byte store, which needs no clearing.
module byte_ring_buffer #(
  parameter int BUF_DEPTH = 256,
  parameter int MAX_READ  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic [brb_pkg::KIND_W-1:0]  in_kind,
  input  logic [brb_pkg::BYTE_W-1:0]  in_write_byte,
  input  logic                        in_write_last,
  input  logic [brb_pkg::LEN_W-1:0]   in_read_length,
  output logic                        empty,
  input  logic                        pop,
  output logic [brb_pkg::KIND_W-1:0]  out_op_kind,
  output logic [brb_pkg::BYTE_W-1:0]  out_data_byte,
  output logic                        out_byte_valid,
  output logic [brb_pkg::CNT_W-1:0]   out_transfer_count,
  output logic                        out_last_of_run,
  output logic [brb_pkg::CNT_W-1:0]   out_fill_level,
  input  logic                        cfg_wr_en,
  input  logic [brb_pkg::CNT_W-1:0]   cfg_wr_data
);
  import brb_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_push;
  result_t res;
  logic    res_full;

  // Front end: takes items, drops unknown kinds, queues commands.
  brb_front #(.MAX_READ(MAX_READ)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_write_byte  (in_write_byte),
    .in_write_last  (in_write_last),
    .in_read_length (in_read_length),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Back end: ring buffer store and sequencer.
  brb_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .res_push    (res_push),
    .res         (res),
    .res_full    (res_full)
  );

  // Result queue toward the consumer.
  brb_out_q u_out_q (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_push           (res_push),
    .res                (res),
    .res_full           (res_full),
    .empty              (empty),
    .pop                (pop),
    .out_op_kind        (out_op_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_valid     (out_byte_valid),
    .out_transfer_count (out_transfer_count),
    .out_last_of_run    (out_last_of_run),
    .out_fill_level     (out_fill_level)
  );

endmodule

@@ rtl/core/brb_checker.sv @@
module brb_checker #(
  parameter int BUF_DEPTH = 256
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        empty,
  input logic                        pop,
  input logic [brb_pkg::KIND_W-1:0]  out_op_kind,
  input logic [brb_pkg::BYTE_W-1:0]  out_data_byte,
  input logic                        out_byte_valid,
  input logic [brb_pkg::CNT_W-1:0]   out_transfer_count,
  input logic                        out_last_of_run,
  input logic [brb_pkg::CNT_W-1:0]   out_fill_level
);
  import brb_pkg::*;

  localparam logic [CNT_W:0] DepthC = (CNT_W + 1)'(BUF_DEPTH);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data_byte) && $stable(out_op_kind)
      && $stable(out_transfer_count) && $stable(out_fill_level)))
    else $error("waiting result changed before it was taken");

  // The fill level never exceeds the store depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ({1'b0, out_fill_level} <= DepthC))
    else $error("fill level beyond store depth");

  // Only read bytes come as results that are not the last of their run.
  a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last_of_run) |->
      (out_byte_valid && (out_op_kind == KIND_READ) && (out_transfer_count == '0)))
    else $error("non-final result that is not a read byte");

  // A clear answers with an empty buffer and closes its run.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_op_kind == KIND_CLEAR)) |->
      ((out_fill_level == '0) && out_last_of_run && !out_byte_valid))
    else $error("clear result with wrong fields");

endmodule

bind byte_ring_buffer brb_checker #(.BUF_DEPTH(BUF_DEPTH)) u_brb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .empty              (empty),
  .pop                (pop),
  .out_op_kind        (out_op_kind),
  .out_data_byte      (out_data_byte),
  .out_byte_valid     (out_byte_valid),
  .out_transfer_count (out_transfer_count),
  .out_last_of_run    (out_last_of_run),
  .out_fill_level     (out_fill_level)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import brb_pkg::*;

  // Kind value that the block ignores.
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int RING_DEPTH   = 256;
  localparam int READ_MAX     = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One row of the directed stimulus table.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] wbyte;
    logic              wlast;
    logic [LEN_W-1:0]  rlen;
    logic              typed;
    result_t           want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [KIND_W-1:0] in_kind = KIND_WRITE;
  logic [BYTE_W-1:0] in_write_byte = '0;
  logic              in_write_last = 1'b0;
  logic [LEN_W-1:0]  in_read_length = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [KIND_W-1:0] out_op_kind;
  logic [BYTE_W-1:0] out_data_byte;
  logic              out_byte_valid;
  logic [CNT_W-1:0]  out_transfer_count;
  logic              out_last_of_run;
  logic [CNT_W-1:0]  out_fill_level;
  logic              cfg_wr_en = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data = '0;

  // Ring model state, kept alongside the block.
  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  int                wr_ptr = 0;
  int                rd_ptr = 0;
  int                held = 0;
  int                burst_cnt = 0;
  int                cap_reg = 256;

  result_t           pending_results [$];
  stim_row_t         directed_rows [$];
  int                mismatches = 0;
  int                items_sent = 0;
  int                results_seen = 0;
  int                cap_settings = 0;
  int                cycle_count = 0;
  bit                quiet_stretch = 1'b0;

  byte_ring_buffer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_kind            (in_kind),
    .in_write_byte      (in_write_byte),
    .in_write_last      (in_write_last),
    .in_read_length     (in_read_length),
    .empty              (empty),
    .pop                (pop),
    .out_op_kind        (out_op_kind),
    .out_data_byte      (out_data_byte),
    .out_byte_valid     (out_byte_valid),
    .out_transfer_count (out_transfer_count),
    .out_last_of_run    (out_last_of_run),
    .out_fill_level     (out_fill_level),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A cycle counter bounds the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $display("Run stopped at the cycle limit with %0d results pending.",
               pending_results.size());
      $finish;
    end
  end

  function automatic result_t make_result(logic [KIND_W-1:0] op, logic [BYTE_W-1:0] data,
                                          logic valid, int count, logic last, int fill);
    result_t r;
    r.op_kind        = op;
    r.data_byte      = data;
    r.byte_valid     = valid;
    r.transfer_count = count[CNT_W-1:0];
    r.last_of_run    = last;
    r.fill_level     = fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic int ring_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return cap_reg;
  endfunction

  function automatic int ring_next(int idx);
    return (idx + 1 >= ring_capacity()) ? 0 : idx + 1;
  endfunction

  // Works out the results of one accepted item and updates the ring model.
  task automatic predict_ring(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] wbyte,
                              logic wlast, logic [LEN_W-1:0] rlen);
    int n;
    int len;
    logic [BYTE_W-1:0] b;
    case (kind)
      KIND_WRITE: begin
        if (held < ring_capacity()) begin
          if (wr_ptr < RING_DEPTH) ring_bytes[wr_ptr] = wbyte;
          wr_ptr = ring_next(wr_ptr);
          held++;
          if (burst_cnt < int'(CNT_MAX)) burst_cnt++;
        end
        if (wlast) begin
          pending_results.push_back(make_result(KIND_WRITE, '0, 1'b0, burst_cnt, 1'b1, held));
          burst_cnt = 0;
        end
      end
      KIND_READ: begin
        len = (int'(rlen) > READ_MAX) ? READ_MAX : int'(rlen);
        n = (held < len) ? held : len;
        if (n == 0) begin
          pending_results.push_back(make_result(KIND_READ, '0, 1'b0, 0, 1'b1, held));
        end else begin
          for (int i = 0; i < n; i++) begin
            b = (rd_ptr < RING_DEPTH) ? ring_bytes[rd_ptr] : '0;
            rd_ptr = ring_next(rd_ptr);
            held--;
            pending_results.push_back(make_result(KIND_READ, b, 1'b1,
                                                  (i + 1 == n) ? n : 0, i + 1 == n, held));
          end
        end
      end
      KIND_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
        held = 0;
        pending_results.push_back(make_result(KIND_CLEAR, '0, 1'b0, 0, 1'b1, 0));
      end
      default: begin
      end
    endcase
  endtask

  // Offers one item and waits until the block takes it.
  task automatic send_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] wbyte, logic wlast,
                           logic [LEN_W-1:0] rlen, logic typed, result_t want);
    push           <= 1'b1;
    in_kind        <= kind;
    in_write_byte  <= wbyte;
    in_write_last  <= wlast;
    in_read_length <= rlen;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_ring(kind, wbyte, wlast, rlen);
    if (typed) pending_results[$] = want;
    if (kind != KIND_NONE) items_sent++;
    if (!quiet_stretch && $urandom_range(99) < 6) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_plain(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] wbyte, logic wlast,
                            logic [LEN_W-1:0] rlen);
    send_item(kind, wbyte, wlast, rlen, 1'b0, '0);
  endtask

  // Lets every pending result drain, then lets items that give none settle.
  task automatic wait_quiet();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(int value, bit clear_after);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = value;
    cap_settings++;
    if (clear_after)
      send_plain(KIND_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
  endtask

  // Mixed traffic: mostly well-formed bursts and reads, some noise.
  task automatic run_traffic(int n_items);
    int start;
    int pick;
    int blen;
    bit abandon;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        if (ring_capacity() <= 32 && $urandom_range(3) == 0)
          blen = ring_capacity() + $urandom_range(1, 4);
        else
          blen = $urandom_range(1, 16);
        abandon = ($urandom_range(9) == 0);
        for (int i = 0; i < blen; i++)
          send_plain(KIND_WRITE, BYTE_W'($urandom), (i == blen - 1) && !abandon,
                     LEN_W'($urandom));
      end else if (pick < 85) begin
        if ($urandom_range(4) == 0)
          send_plain(KIND_READ, BYTE_W'($urandom), 1'($urandom),
                     LEN_W'($urandom_range(0, 127)));
        else
          send_plain(KIND_READ, BYTE_W'($urandom), 1'($urandom),
                     LEN_W'($urandom_range(0, 70)));
      end else if (pick < 92) begin
        send_plain(KIND_CLEAR, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else if (pick < 96) begin
        send_plain(KIND_NONE, BYTE_W'($urandom), 1'($urandom), LEN_W'($urandom));
      end else begin
        send_plain(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom), 1'($urandom),
                   LEN_W'($urandom));
      end
    end
  endtask

  // One line per mismatch, counted.
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Result side: random pop stalls, each accepted item checked in order.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, op_kind", int'(out_op_kind), -1);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_op_kind !== exp_r.op_kind)
            report_mismatch("op_kind", int'(out_op_kind), int'(exp_r.op_kind));
          if (out_data_byte !== exp_r.data_byte)
            report_mismatch("data_byte", int'(out_data_byte), int'(exp_r.data_byte));
          if (out_byte_valid !== exp_r.byte_valid)
            report_mismatch("byte_valid", int'(out_byte_valid), int'(exp_r.byte_valid));
          if (out_transfer_count !== exp_r.transfer_count)
            report_mismatch("transfer_count", int'(out_transfer_count),
                            int'(exp_r.transfer_count));
          if (out_last_of_run !== exp_r.last_of_run)
            report_mismatch("last_of_run", int'(out_last_of_run), int'(exp_r.last_of_run));
          if (out_fill_level !== exp_r.fill_level)
            report_mismatch("fill_level", int'(out_fill_level), int'(exp_r.fill_level));
        end
      end
      pop <= quiet_stretch || ($urandom_range(99) >= 6);
    end
  end

  // Stimulus.
  initial begin
    int caps [$];

    // Directed table, walked after reset with the reset capacity.
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd0, 1'b1,
                              make_result(KIND_READ, '0, 1'b0, 0, 1'b1, 0)});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd5, 1'b1,
                              make_result(KIND_READ, '0, 1'b0, 0, 1'b1, 0)});
    directed_rows.push_back('{KIND_CLEAR, 8'h00, 1'b0, 7'd0, 1'b1,
                              make_result(KIND_CLEAR, '0, 1'b0, 0, 1'b1, 0)});
    directed_rows.push_back('{KIND_WRITE, 8'h00, 1'b0, 7'd0, 1'b0, '0});
    directed_rows.push_back('{KIND_WRITE, 8'hFF, 1'b0, 7'd127, 1'b0, '0});
    directed_rows.push_back('{KIND_WRITE, 8'hA5, 1'b1, 7'd0, 1'b1,
                              make_result(KIND_WRITE, '0, 1'b0, 3, 1'b1, 3)});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd2, 1'b0, '0});
    // An oversized read saturates and then runs short of data.
    directed_rows.push_back('{KIND_READ, 8'hFF, 1'b1, 7'd127, 1'b0, '0});
    directed_rows.push_back('{KIND_NONE, 8'hFF, 1'b1, 7'd127, 1'b0, '0});
    directed_rows.push_back('{KIND_WRITE, 8'h5A, 1'b1, 7'd0, 1'b1,
                              make_result(KIND_WRITE, '0, 1'b0, 1, 1'b1, 1)});
    // A clear in the middle of a burst keeps the burst count.
    directed_rows.push_back('{KIND_WRITE, 8'h3C, 1'b0, 7'd0, 1'b0, '0});
    directed_rows.push_back('{KIND_CLEAR, 8'hFF, 1'b1, 7'd127, 1'b1,
                              make_result(KIND_CLEAR, '0, 1'b0, 0, 1'b1, 0)});
    directed_rows.push_back('{KIND_WRITE, 8'h81, 1'b1, 7'd0, 1'b1,
                              make_result(KIND_WRITE, '0, 1'b0, 2, 1'b1, 1)});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd64, 1'b0, '0});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd1, 1'b1,
                              make_result(KIND_READ, '0, 1'b0, 0, 1'b1, 0)});
    directed_rows.push_back('{KIND_WRITE, 8'h7E, 1'b1, 7'd0, 1'b1,
                              make_result(KIND_WRITE, '0, 1'b0, 1, 1'b1, 1)});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd0, 1'b1,
                              make_result(KIND_READ, '0, 1'b0, 0, 1'b1, 1)});
    directed_rows.push_back('{KIND_READ, 8'h00, 1'b0, 7'd65, 1'b0, '0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].kind, directed_rows[i].wbyte, directed_rows[i].wlast,
                directed_rows[i].rlen, directed_rows[i].typed, directed_rows[i].want);

    // Random traffic at the reset capacity, then at a range of settings.
    run_traffic(24);
    caps = '{1, 2, 0, 511, 300, 255, 3, 17};
    caps.push_back($urandom_range(1, 256));
    foreach (caps[i]) begin
      quiet_stretch = (i == 4);
      write_capacity(caps[i], 1'b1);
      run_traffic(24);
    end
    quiet_stretch = 1'b0;

    // Capacity changed without a clear, taken while the ring is empty.
    while (held > 0)
      send_plain(KIND_READ, BYTE_W'($urandom), 1'($urandom),
                 LEN_W'((held > 64) ? 64 : held));
    write_capacity($urandom_range(4, 40), 1'b0);
    run_traffic(24);

    wait_quiet();
    $display("Sent %0d items over %0d capacity settings; checked %0d results.",
             items_sent, cap_settings + 1, results_seen);
    $display("Covered drops, short and saturated reads, mid-burst clears and capacity changes.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
